### design/assert_macros.svh
// assertion helpers used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PIOC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define PIOC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### design/pioc_pkg.sv
`timescale 1ns / 1ps

package pioc_pkg;

	localparam int PIN_COUNT = 32;
	localparam logic [31:0] PIN_MASK = 32'hffff_ffff;

	// transaction kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_EVENT = 2'd2;

	// pin levels
	localparam logic [1:0] LVL_LOW     = 2'd0;
	localparam logic [1:0] LVL_HIGH    = 2'd1;
	localparam logic [1:0] LVL_UNKNOWN = 2'd2;

	// line groups (upper bits of the line number)
	localparam logic [1:0] LINE_PAD  = 2'd0;
	localparam logic [1:0] LINE_PERA = 2'd1;
	localparam logic [1:0] LINE_PERB = 2'd2;

	// register byte offsets
	localparam logic [8:0] OFF_PIO_EN     = 9'h000;
	localparam logic [8:0] OFF_PIO_DIS    = 9'h004;
	localparam logic [8:0] OFF_PIO_STAT   = 9'h008;
	localparam logic [8:0] OFF_OE_EN      = 9'h010;
	localparam logic [8:0] OFF_OE_DIS     = 9'h014;
	localparam logic [8:0] OFF_OE_STAT    = 9'h018;
	localparam logic [8:0] OFF_FLT_EN     = 9'h020;
	localparam logic [8:0] OFF_FLT_DIS    = 9'h024;
	localparam logic [8:0] OFF_FLT_STAT   = 9'h028;
	localparam logic [8:0] OFF_SET_DATA   = 9'h030;
	localparam logic [8:0] OFF_CLR_DATA   = 9'h034;
	localparam logic [8:0] OFF_OUT_DATA   = 9'h038;
	localparam logic [8:0] OFF_PIN_DATA   = 9'h03c;
	localparam logic [8:0] OFF_IRQ_EN     = 9'h040;
	localparam logic [8:0] OFF_IRQ_DIS    = 9'h044;
	localparam logic [8:0] OFF_IRQ_MASK   = 9'h048;
	localparam logic [8:0] OFF_IRQ_STAT   = 9'h04c;
	localparam logic [8:0] OFF_MD_EN      = 9'h050;
	localparam logic [8:0] OFF_MD_DIS     = 9'h054;
	localparam logic [8:0] OFF_MD_STAT    = 9'h058;
	localparam logic [8:0] OFF_PU_DIS     = 9'h060;
	localparam logic [8:0] OFF_PU_EN      = 9'h064;
	localparam logic [8:0] OFF_PU_STAT    = 9'h068;
	localparam logic [8:0] OFF_SEL_A      = 9'h070;
	localparam logic [8:0] OFF_SEL_B      = 9'h074;
	localparam logic [8:0] OFF_SEL_STAT   = 9'h078;
	localparam logic [8:0] OFF_OWE_EN     = 9'h0a0;
	localparam logic [8:0] OFF_OWE_DIS    = 9'h0a4;
	localparam logic [8:0] OFF_OWE_STAT   = 9'h0a8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [8:0]  offset;
		logic [31:0] wdata;
		logic [6:0]  pin;
		logic [1:0]  level;
	} item_t;

	typedef struct packed {
		logic [31:0] rdata;
		logic        irq;
		logic [31:0] drive_mask;
		logic [31:0] drive_levels;
		logic        route_valid;
		logic [6:0]  route_line;
		logic [1:0]  route_level;
	} result_t;

endpackage

### design/parallel_io_pin_controller_unit.sv
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                                         | tuser
// s_*     | in  | offset 9, wdata 32, pin 7, level 2, zero fill to 56        | kind 2
// m_*     | out | rdata 32, irq 1, drive_mask 32, drive_levels 32,          | route_valid 1
//         |     | route_line 7, route_level 2, zero fill to 112               |
//
// one transaction per clock sustained while m_tready stays high; each input transaction
// gives one result through the input register, then the state update and result register
// each transaction makes a single pass through the register file decode logic
// arst_n clears all control state and the pin registers to their reset values
// a stalled result holds in the output register while the input register still
// takes one more transaction; s_tready drops only when both are full and m_tready is low

module parallel_io_pin_controller_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [55:0]  s_tdata,   // offset, wdata, pin, level
	input  logic [1:0]   s_tuser,   // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // rdata, irq, drive_mask, drive_levels, route_line, route_level
	output logic         m_tuser    // route_valid
);

	logic              valid_s1, valid_s2;
	pioc_pkg::item_t   item_s1;
	pioc_pkg::result_t res, res_s2;
	logic              adv, s_take;

	// the input stage moves on when the output register is free or being emptied
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign s_take   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// input payload register, unpacked from the stream fields
	always_ff @(posedge clk) begin
		if (s_take) begin
			item_s1.kind   <= s_tuser;
			item_s1.offset <= s_tdata[8:0];
			item_s1.wdata  <= s_tdata[40:9];
			item_s1.pin    <= s_tdata[47:41];
			item_s1.level  <= s_tdata[49:48];
		end
	end

	// register file, decode and pin logic; state commits when the stage advances
	pioc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.route_valid;
	assign m_tdata  = {6'd0, res_s2.route_level, res_s2.route_line, res_s2.drive_levels,
		res_s2.drive_mask, res_s2.irq, res_s2.rdata};

endmodule

### design/pioc_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pioc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  pioc_pkg::item_t   item,
	output pioc_pkg::result_t res
);

	logic [31:0] pio_en_q, oe_q, flt_q, out_data_q, pin_data_q, irq_mask_q, irq_stat_q;
	logic [31:0] md_q, pu_q, sel_b_q, owe_q, unk_q;
	logic        irq_line_q;

	logic [31:0] pio_en_d, oe_d, flt_d, out_data_d, pin_data_d, irq_mask_d, irq_stat_d;
	logic [31:0] md_d, pu_d, sel_b_d, owe_d, unk_d;
	logic        irq_line_d;

	logic [31:0] v, pin_bit;
	logic [1:0]  lvl, grp;
	logic        bsel, pio, oe;

	always_comb begin
		v       = item.wdata & pioc_pkg::PIN_MASK;
		pin_bit = 32'd1 << item.pin[4:0];
		grp     = item.pin[6:5];
		lvl     = (item.level > pioc_pkg::LVL_UNKNOWN) ? pioc_pkg::LVL_UNKNOWN : item.level;
		bsel    = |(sel_b_q & pin_bit);
		pio     = |(pio_en_q & pin_bit);
		oe      = |(oe_q & pin_bit);

		pio_en_d   = pio_en_q;
		oe_d       = oe_q;
		flt_d      = flt_q;
		out_data_d = out_data_q;
		pin_data_d = pin_data_q;
		irq_mask_d = irq_mask_q;
		irq_stat_d = irq_stat_q;
		md_d       = md_q;
		pu_d       = pu_q;
		sel_b_d    = sel_b_q;
		owe_d      = owe_q;
		unk_d      = unk_q;
		irq_line_d = irq_line_q;
		res        = '0;

		case (item.kind)
			pioc_pkg::KIND_READ: begin
				case (item.offset)
					pioc_pkg::OFF_PIO_STAT: res.rdata = pio_en_q;
					pioc_pkg::OFF_OE_STAT:  res.rdata = oe_q;
					pioc_pkg::OFF_FLT_STAT: res.rdata = flt_q;
					pioc_pkg::OFF_OUT_DATA: res.rdata = out_data_q;
					pioc_pkg::OFF_PIN_DATA: res.rdata = (pin_data_q & ~unk_q) | (pu_q & unk_q);
					pioc_pkg::OFF_IRQ_MASK: res.rdata = irq_mask_q;
					pioc_pkg::OFF_IRQ_STAT: begin
						res.rdata  = irq_stat_q;
						irq_stat_d = '0;
						irq_line_d = 1'b0;
					end
					pioc_pkg::OFF_MD_STAT:  res.rdata = md_q;
					pioc_pkg::OFF_PU_STAT:  res.rdata = pu_q;
					pioc_pkg::OFF_SEL_STAT: res.rdata = sel_b_q;
					pioc_pkg::OFF_OWE_STAT: res.rdata = owe_q;
					default:                res.rdata = '0;
				endcase
			end
			pioc_pkg::KIND_WRITE: begin
				case (item.offset)
					pioc_pkg::OFF_PIO_EN:  pio_en_d = pio_en_q | v;
					pioc_pkg::OFF_PIO_DIS: pio_en_d = pio_en_q & ~v;
					pioc_pkg::OFF_OE_EN:   oe_d = oe_q | v;
					pioc_pkg::OFF_OE_DIS:  oe_d = oe_q & ~v;
					pioc_pkg::OFF_FLT_EN:  flt_d = flt_q | v;
					pioc_pkg::OFF_FLT_DIS: flt_d = flt_q & ~v;
					pioc_pkg::OFF_SET_DATA: begin
						out_data_d       = out_data_q | v;
						res.drive_mask   = v & oe_q;
						res.drive_levels = v & oe_q;
					end
					pioc_pkg::OFF_CLR_DATA: begin
						out_data_d     = out_data_q & ~v;
						res.drive_mask = v & oe_q;
					end
					pioc_pkg::OFF_OUT_DATA: begin
						out_data_d       = (out_data_q & ~owe_q) | (v & owe_q);
						res.drive_mask   = owe_q;
						res.drive_levels = v & owe_q;
					end
					pioc_pkg::OFF_IRQ_EN:  irq_mask_d = irq_mask_q | v;
					pioc_pkg::OFF_IRQ_DIS: irq_mask_d = irq_mask_q & ~v;
					pioc_pkg::OFF_MD_EN:   md_d = md_q | v;
					pioc_pkg::OFF_MD_DIS:  md_d = md_q & ~v;
					pioc_pkg::OFF_PU_DIS:  pu_d = pu_q & ~v;
					pioc_pkg::OFF_PU_EN:   pu_d = pu_q | v;
					pioc_pkg::OFF_SEL_A:   sel_b_d = sel_b_q & ~v;
					pioc_pkg::OFF_SEL_B:   sel_b_d = sel_b_q | v;
					pioc_pkg::OFF_OWE_EN:  owe_d = owe_q | v;
					pioc_pkg::OFF_OWE_DIS: owe_d = owe_q & ~v;
					default: ;
				endcase
			end
			pioc_pkg::KIND_EVENT: begin
				if (grp == pioc_pkg::LINE_PAD) begin
					if (!oe) begin
						if (pio) begin
							pin_data_d = (pin_data_q & ~pin_bit) |
								((lvl == pioc_pkg::LVL_HIGH) ? pin_bit : '0);
							unk_d = (lvl == pioc_pkg::LVL_UNKNOWN) ? (unk_q | pin_bit)
								: (unk_q & ~pin_bit);
							if (pin_data_d != pin_data_q) begin
								irq_stat_d = irq_stat_q | pin_bit;
								irq_line_d = |(irq_stat_d & irq_mask_q);
							end
						end else begin
							// pad owned by a peripheral: pass to its line
							res.route_valid = 1'b1;
							res.route_line  = {bsel ? pioc_pkg::LINE_PERB : pioc_pkg::LINE_PERA,
								item.pin[4:0]};
							res.route_level = lvl;
						end
					end
				end else if ((grp == pioc_pkg::LINE_PERA && !bsel) ||
					(grp == pioc_pkg::LINE_PERB && bsel)) begin
					if (!pio) begin
						res.route_valid = 1'b1;
						res.route_line  = {pioc_pkg::LINE_PAD, item.pin[4:0]};
						res.route_level = lvl;
					end
				end
			end
			default: ;
		endcase

		res.irq = irq_line_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pio_en_q   <= pioc_pkg::PIN_MASK;
			oe_q       <= '0;
			flt_q      <= '0;
			out_data_q <= '0;
			pin_data_q <= '0;
			irq_mask_q <= '0;
			irq_stat_q <= '0;
			md_q       <= '0;
			pu_q       <= '0;
			sel_b_q    <= '0;
			owe_q      <= '0;
			unk_q      <= pioc_pkg::PIN_MASK;
			irq_line_q <= 1'b0;
		end else if (fire) begin
			pio_en_q   <= pio_en_d;
			oe_q       <= oe_d;
			flt_q      <= flt_d;
			out_data_q <= out_data_d;
			pin_data_q <= pin_data_d;
			irq_mask_q <= irq_mask_d;
			irq_stat_q <= irq_stat_d;
			md_q       <= md_d;
			pu_q       <= pu_d;
			sel_b_q    <= sel_b_d;
			owe_q      <= owe_d;
			unk_q      <= unk_d;
			irq_line_q <= irq_line_d;
		end
	end

	// status read clears status and the line
	`PIOC_ASSERT(a_stat_clr, fire && item.kind == pioc_pkg::KIND_READ && item.offset == pioc_pkg::OFF_IRQ_STAT |=> irq_stat_q == '0 && !irq_line_q, "status read did not clear")
	// pads driven as outputs never change pin data
	`PIOC_ASSERT(a_oe_hold, fire && item.kind == pioc_pkg::KIND_EVENT && item.pin[6:5] == pioc_pkg::LINE_PAD && (|(oe_q & (32'd1 << item.pin[4:0]))) |=> $stable(pin_data_q), "output pad changed pin data")
	// drive levels only where driven
	`PIOC_ASSERT_NEVER(a_lvl_mask, fire && (res.drive_levels & ~res.drive_mask) != '0, "drive level outside mask")
	// forwarding only comes from pin events
	`PIOC_ASSERT(a_route_kind, fire && res.route_valid |-> item.kind == pioc_pkg::KIND_EVENT, "route from bus transaction")

endmodule
